[hw/rtl/tbeq_pkg.sv]
// shared types and constants for the three-band biquad equalizer
`timescale 1ns / 1ps
`default_nettype none

package tbeq_pkg;

    // default sizes
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int MAX_CHANNELS_DEF = 8;

    // fixed field widths
    localparam int CHAN_W     = 3;
    localparam int COEF_W     = 20;
    localparam int COEF_FRAC  = 16;
    localparam int HIST_GUARD = 4;

    // filter structure
    localparam int NUM_STAGES = 3;
    localparam int NUM_TAPS   = 4;
    localparam int MAC_STEPS  = 5;

    // configuration registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int B_REG_W    = 3 * COEF_W;
    localparam int A_REG_W    = 2 * COEF_W;
    localparam logic [B_REG_W-1:0] B_RESET = B_REG_W'(1 << COEF_FRAC);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_B  = 3'd0,
        REG_LOW_A  = 3'd1,
        REG_MID_B  = 3'd2,
        REG_MID_A  = 3'd3,
        REG_HIGH_B = 3'd4,
        REG_HIGH_A = 3'd5
    } tbeq_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_WRITE,
        ST_DONE
    } tbeq_state_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic add_en;
        logic sub;
    } tbeq_mac_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/tbeq_if.sv]
// channel interfaces: sample input, result output and configuration writes
`timescale 1ns / 1ps
`default_nettype none

interface tbeq_in_if import tbeq_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [CHAN_W-1:0]              channel;
    logic                           restart;

    modport source (output valid, sample_in, channel, restart, input ready);
    modport sink   (input valid, sample_in, channel, restart, output ready);
endinterface

interface tbeq_out_if import tbeq_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic [CHAN_W-1:0]              channel_out;

    modport source (output valid, sample_out, channel_out, input ready);
    modport sink   (input valid, sample_out, channel_out, output ready);
endinterface

interface tbeq_cfg_if import tbeq_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/three_band_biquad_equalizer_top.sv]
// three-band equalizer top level: sequencer, history memory, coefficient registers
//
// Usage
//   samples: one item is a signed sample, its channel and a restart flag.
//   results: one item per input item, the equalized sample and its channel.
//   cfg: register writes (index 0..5: low b, low a, mid b, mid a, high b,
//   high a); always ready, meant to be written only while the block is idle.
// Each item runs low shelf, peak and high shelf in turn on one shared
// multiply-accumulate unit: per stage one history row read, five products
// plus one accumulate flush, and one history row write.
// A new item is taken only after the previous one has passed its final
// state; samples.ready is high only while the sequencer is free. The result
// register lets the next item start while a result waits; if the receiver
// still holds the earlier result when the next one is done, the sequencer
// waits in its final state.
// Reset clears the per-channel history valid bits, so every channel starts
// from an all-zero history with no clearing pass; coefficients reset to
// pass-through (b0 = 1.0, all others zero).
`timescale 1ns / 1ps
`default_nettype none

module three_band_biquad_equalizer_top import tbeq_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tbeq_in_if.sink   samples,
    tbeq_out_if.source results,
    tbeq_cfg_if.sink  cfg
);

    localparam int HIST_W    = SAMPLE_WIDTH + HIST_GUARD;
    localparam int ROW_W     = NUM_TAPS * HIST_W;
    localparam int ROWS      = MAX_CHANNELS * NUM_STAGES;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CH_IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_EXT_W  = 5;
    localparam int ROW_SUM_W = 6;
    localparam int STEP_W    = 3;
    localparam logic [1:0] LAST_STAGE = 2'(NUM_STAGES - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAC_STEPS);

    // step codes of the multiply sequence
    localparam logic [STEP_W-1:0] STEP_B0 = 3'd0;
    localparam logic [STEP_W-1:0] STEP_B1 = 3'd1;
    localparam logic [STEP_W-1:0] STEP_B2 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_A1 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_A2 = 3'd4;

    tbeq_state_t state_reg, state_next;

    logic [B_REG_W-1:0]       b_coefs_reg [NUM_STAGES];
    logic [A_REG_W-1:0]       a_coefs_reg [NUM_STAGES];
    logic [MAX_CHANNELS-1:0]  hist_ok_reg;
    logic [ROW_W-1:0]         hist_mem [ROWS];
    logic [ROW_W-1:0]         rd_row_reg;

    logic signed [HIST_W-1:0] x_reg;
    logic [CHAN_W-1:0]        ch_reg;
    logic                     in_range_reg;
    logic                     use_hist_reg;
    logic [1:0]               stage_reg;
    logic [STEP_W-1:0]        step_reg;

    logic                     out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic [CHAN_W-1:0]        out_chan_reg;

    logic                     accept;
    logic                     out_free;
    logic                     load_out;
    logic                     mem_we;
    tbeq_mac_ctl_t            mac_ctl;
    logic signed [COEF_W-1:0] coef;
    logic signed [HIST_W-1:0] operand;
    logic signed [HIST_W-1:0] mac_y;
    logic signed [HIST_W-1:0] tap [NUM_TAPS];
    logic [ROW_W-1:0]         new_row;
    logic [CH_EXT_W-1:0]      in_ch_ext;
    logic                     in_range;
    logic [ROW_SUM_W-1:0]     row_sum;
    logic [HIST_W-SAMPLE_WIDTH:0] out_top;
    logic signed [SAMPLE_WIDTH-1:0] out_sat;

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                b_coefs_reg[s] <= B_RESET;
                a_coefs_reg[s] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LOW_B:  b_coefs_reg[0] <= cfg.data[B_REG_W-1:0];
                REG_LOW_A:  a_coefs_reg[0] <= cfg.data[A_REG_W-1:0];
                REG_MID_B:  b_coefs_reg[1] <= cfg.data[B_REG_W-1:0];
                REG_MID_A:  a_coefs_reg[1] <= cfg.data[A_REG_W-1:0];
                REG_HIGH_B: b_coefs_reg[2] <= cfg.data[B_REG_W-1:0];
                REG_HIGH_A: a_coefs_reg[2] <= cfg.data[A_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    // incoming channel checks
    assign in_ch_ext = {2'b00, samples.channel};
    assign in_range  = in_ch_ext < CH_EXT_W'(MAX_CHANNELS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (samples.valid) state_next = ST_READ;
            ST_READ:  state_next = ST_MAC;
            ST_MAC:   if (step_reg == STEP_LAST) state_next = ST_WRITE;
            ST_WRITE: state_next = (stage_reg == LAST_STAGE) ? ST_DONE : ST_READ;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        samples.ready  = 1'b0;
        mac_ctl        = '0;
        mem_we         = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE:  samples.ready = 1'b1;
            ST_READ:  mac_ctl.clear = 1'b1;
            ST_MAC:
            begin
                mac_ctl.mul_en = (step_reg != STEP_LAST);
                mac_ctl.add_en = (step_reg != STEP_B0);
                mac_ctl.sub    = (step_reg == STEP_A1) || (step_reg == STEP_A2);
            end
            ST_WRITE: mem_we   = in_range_reg;
            ST_DONE:  load_out = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // stage and step counters, history valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= '0;
            step_reg    <= '0;
            hist_ok_reg <= '0;
        end
        else
        begin
            if (accept)
                stage_reg <= '0;
            else if (state_reg == ST_WRITE && stage_reg != LAST_STAGE)
                stage_reg <= stage_reg + 2'd1;

            if (state_reg == ST_MAC)
                step_reg <= step_reg + STEP_W'(1);
            else
                step_reg <= '0;

            if (load_out && in_range_reg)
                hist_ok_reg[CH_IDX_W'({2'b00, ch_reg})] <= 1'b1;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg        <= HIST_W'(samples.sample_in);
            ch_reg       <= samples.channel;
            in_range_reg <= in_range;
            use_hist_reg <= in_range && !samples.restart
                            && hist_ok_reg[in_ch_ext[CH_IDX_W-1:0]];
        end
        else if (state_reg == ST_WRITE)
            x_reg <= mac_y;
    end

    // history memory: one row of four taps per channel and stage
    assign row_sum = {2'b00, ch_reg, 1'b0} + {3'b000, ch_reg} + {4'b0000, stage_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[row_sum[ROW_AW-1:0]] <= new_row;
        rd_row_reg <= hist_mem[row_sum[ROW_AW-1:0]];
    end

    // taps read as zero for a fresh, restarted or out-of-range channel
    always_comb
    begin
        for (int t = 0; t < NUM_TAPS; t++)
            tap[t] = use_hist_reg ? rd_row_reg[t*HIST_W +: HIST_W] : '0;
    end

    // shifted history: x1 <= x, x2 <= x1, y1 <= y, y2 <= y1
    assign new_row = {tap[2], mac_y, tap[0], x_reg};

    // operand and coefficient for the current step
    always_comb
    begin
        case (step_reg)
            STEP_B0:
            begin
                operand = x_reg;
                coef    = b_coefs_reg[stage_reg][0 +: COEF_W];
            end
            STEP_B1:
            begin
                operand = tap[0];
                coef    = b_coefs_reg[stage_reg][COEF_W +: COEF_W];
            end
            STEP_B2:
            begin
                operand = tap[1];
                coef    = b_coefs_reg[stage_reg][2*COEF_W +: COEF_W];
            end
            STEP_A1:
            begin
                operand = tap[2];
                coef    = a_coefs_reg[stage_reg][0 +: COEF_W];
            end
            STEP_A2:
            begin
                operand = tap[3];
                coef    = a_coefs_reg[stage_reg][COEF_W +: COEF_W];
            end
            default:
            begin
                operand = '0;
                coef    = '0;
            end
        endcase
    end

    tbeq_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk     (clk),
        .ctl     (mac_ctl),
        .coef    (coef),
        .operand (operand),
        .y       (mac_y)
    );

    // clamp the last stage to the sample range
    assign out_top = x_reg[HIST_W-1:SAMPLE_WIDTH-1];

    always_comb
    begin
        if ((&out_top) || !(|out_top))
            out_sat = x_reg[SAMPLE_WIDTH-1:0];
        else
            out_sat = {x_reg[HIST_W-1], {(SAMPLE_WIDTH-1){~x_reg[HIST_W-1]}}};
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sample_reg <= out_sat;
            out_chan_reg   <= ch_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.sample_out  = out_sample_reg;
    assign results.channel_out = out_chan_reg;

    // an accepted item starts at the first stage with a history read
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_READ) && (stage_reg == 2'd0))
        else $error("accepted item did not start at the first stage");

    // a result is only produced once all three stages are written back
    a_result_after_stages: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the final state");

    // the last stage write always leads to the result handoff
    a_last_stage_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) && (stage_reg == LAST_STAGE) |=> state_reg == ST_DONE)
        else $error("sequencer missed the result handoff");

    // the step counter never runs past the accumulate flush
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (step_reg <= STEP_LAST))
        else $error("multiply step counter out of range");

endmodule

`default_nettype wire

[hw/rtl/tbeq_mac.sv]
// shared multiply-accumulate unit with rounding and saturation to the history range
`timescale 1ns / 1ps
`default_nettype none

module tbeq_mac import tbeq_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int HIST_W = SAMPLE_WIDTH + HIST_GUARD
) (
    input  wire logic                     clk,
    input  wire tbeq_mac_ctl_t            ctl,
    input  wire logic signed [COEF_W-1:0] coef,
    input  wire logic signed [HIST_W-1:0] operand,
    output logic signed [HIST_W-1:0]      y
);

    localparam int PROD_W = COEF_W + HIST_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (COEF_FRAC - 1));

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  rnd;
    logic [ACC_W-HIST_W:0]    top_bits;

    // product register, then add or subtract into the accumulator
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg     <= PROD_W'(coef) * PROD_W'(operand);
            prod_sub_reg <= ctl.sub;
        end
        if (ctl.clear)
            acc_reg <= '0;
        else if (ctl.add_en)
            acc_reg <= prod_sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
    end

    assign prod_ext = ACC_W'(prod_reg);

    // round half up, drop the coefficient fraction, clamp to history width
    assign rnd_sum  = acc_reg + ROUND_HALF;
    assign rnd      = rnd_sum >>> COEF_FRAC;
    assign top_bits = rnd[ACC_W-1:HIST_W-1];

    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
            y = rnd[HIST_W-1:0];
        else
            y = {rnd[ACC_W-1], {(HIST_W-1){~rnd[ACC_W-1]}}};
    end

endmodule

`default_nettype wire

[tb/tbeq_eq_checker.sv]
// result checker for the three-band equalizer: tracks filter state, predicts and compares items
`timescale 1ns / 1ps

module tbeq_eq_checker import tbeq_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tbeq_in_if   samples,
    tbeq_out_if  results,
    tbeq_cfg_if  cfg,
    output int   error_count,
    output int   results_owed
);

    localparam int HIST_W = SAMPLE_WIDTH + HIST_GUARD;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [HIST_W-1:0]       tap_t;

    typedef struct {
        sample_t           sample;
        logic [CHAN_W-1:0] chan;
    } eq_result_t;

    // per channel and stage, taps in the order x1, x2, y1, y2
    tap_t               taps [MAX_CHANNELS][NUM_STAGES][NUM_TAPS];
    logic [B_REG_W-1:0] b_coefs [NUM_STAGES];
    logic [A_REG_W-1:0] a_coefs [NUM_STAGES];
    eq_result_t         expected_results [$];

    // signed Q3.16 field idx of a packed coefficient register
    function automatic longint coef_at(logic [B_REG_W-1:0] reg_val, int idx);
        logic signed [COEF_W-1:0] c;
        c = reg_val[idx*COEF_W +: COEF_W];
        return longint'(c);
    endfunction

    function automatic longint saturate_to(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // low shelf, peak, high shelf on one channel's history
    function automatic sample_t equalize_sample(sample_t x_in, int ch, bit restart);
        tap_t   row [NUM_STAGES][NUM_TAPS];
        longint x;
        longint acc;
        bit     in_range;
        in_range = ch < MAX_CHANNELS;
        for (int s = 0; s < NUM_STAGES; s++)
            for (int t = 0; t < NUM_TAPS; t++)
                if (in_range && !restart)
                    row[s][t] = taps[ch][s][t];
                else
                    row[s][t] = '0;
        x = x_in;
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            acc = coef_at(b_coefs[s], 0) * x
                + coef_at(b_coefs[s], 1) * longint'(row[s][0])
                + coef_at(b_coefs[s], 2) * longint'(row[s][1])
                - coef_at(a_coefs[s], 0) * longint'(row[s][2])
                - coef_at(a_coefs[s], 1) * longint'(row[s][3]);
            row[s][1] = row[s][0];
            row[s][0] = tap_t'(x);
            row[s][3] = row[s][2];
            // round half up, then clamp to the history range
            x = saturate_to((acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC, HIST_W);
            row[s][2] = tap_t'(x);
        end
        if (in_range)
            for (int s = 0; s < NUM_STAGES; s++)
                for (int t = 0; t < NUM_TAPS; t++)
                    taps[ch][s][t] = row[s][t];
        return sample_t'(saturate_to(x, SAMPLE_WIDTH));
    endfunction

    always @(posedge clk)
    begin : track
        eq_result_t oldest;
        eq_result_t fresh;
        if (!rst_n)
        begin
            // all histories zero, every stage pass-through
            for (int c = 0; c < MAX_CHANNELS; c++)
                for (int s = 0; s < NUM_STAGES; s++)
                    for (int t = 0; t < NUM_TAPS; t++)
                        taps[c][s][t] = '0;
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                b_coefs[s] = B_RESET;
                a_coefs[s] = '0;
            end
            expected_results.delete();
        end
        else
        begin
            // register writes, unmapped indexes dropped
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_LOW_B:  b_coefs[0] = cfg.data[B_REG_W-1:0];
                    REG_LOW_A:  a_coefs[0] = cfg.data[A_REG_W-1:0];
                    REG_MID_B:  b_coefs[1] = cfg.data[B_REG_W-1:0];
                    REG_MID_A:  a_coefs[1] = cfg.data[A_REG_W-1:0];
                    REG_HIGH_B: b_coefs[2] = cfg.data[B_REG_W-1:0];
                    REG_HIGH_A: a_coefs[2] = cfg.data[A_REG_W-1:0];
                    default: ;
                endcase
            end

            // each result item against the oldest expectation
            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: sample_out %0d, channel_out %0d",
                           results.sample_out, results.channel_out);
                    error_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (results.sample_out !== oldest.sample)
                    begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               oldest.sample, results.sample_out);
                        error_count++;
                    end
                    if (results.channel_out !== oldest.chan)
                    begin
                        $error("channel_out mismatch: expected %0d, actual %0d",
                               oldest.chan, results.channel_out);
                        error_count++;
                    end
                end
            end

            // accepted sample item
            if (samples.valid && samples.ready)
            begin
                fresh.sample = equalize_sample(samples.sample_in, samples.channel,
                                               samples.restart);
                fresh.chan   = samples.channel;
                expected_results.push_back(fresh);
            end
        end
        results_owed = expected_results.size();
    end

endmodule

[tb/tb_three_band_biquad_equalizer_top.sv]
// testbench top for the three-band equalizer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_three_band_biquad_equalizer_top import tbeq_pkg::*;;

    localparam int MAX_CH         = MAX_CHANNELS_DEF;
    localparam int SW             = SAMPLE_WIDTH_DEF;
    localparam int ITEM_LATENCY   = 26;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 130;

    typedef logic signed [SW-1:0] sample_t;

    localparam sample_t FULL_POS = {1'b0, {(SW-1){1'b1}}};
    localparam sample_t FULL_NEG = {1'b1, {(SW-1){1'b0}}};

    // Q3.16 coefficient values
    localparam logic [COEF_W-1:0] COEF_ONE      = COEF_W'(1 << COEF_FRAC);
    localparam logic [COEF_W-1:0] COEF_TWO      = COEF_W'(2 << COEF_FRAC);
    localparam logic [COEF_W-1:0] COEF_HALF     = COEF_W'(1 << (COEF_FRAC - 1));
    localparam logic [COEF_W-1:0] COEF_NEG_HALF = COEF_W'(-(1 << (COEF_FRAC - 1)));
    localparam logic [COEF_W-1:0] COEF_MAX_POS  = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MAX_NEG  = {1'b1, {(COEF_W-1){1'b0}}};

    // register indexes past the map
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef enum {COEF_PASS, COEF_GENTLE, COEF_WILD, COEF_TOP, COEF_BOTTOM} coef_mode_t;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    bit   idle_en = 1'b1;
    int   error_count;
    int   results_owed;
    int   quiet_cycles = 0;

    tbeq_in_if  #(.SAMPLE_WIDTH(SW)) samples_if ();
    tbeq_out_if #(.SAMPLE_WIDTH(SW)) results_if ();
    tbeq_cfg_if                      cfg_if ();

    three_band_biquad_equalizer_top #(
        .MAX_CHANNELS(MAX_CH),
        .SAMPLE_WIDTH(SW)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(samples_if),
        .results(results_if),
        .cfg    (cfg_if)
    );

    tbeq_eq_checker #(
        .MAX_CHANNELS(MAX_CH),
        .SAMPLE_WIDTH(SW)
    ) eq_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_if),
        .results     (results_if),
        .cfg         (cfg_if),
        .error_count (error_count),
        .results_owed(results_owed)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(4, 1);
        return $urandom_range(60, 12);
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            case ($urandom_range(3))
                0: return FULL_POS;
                1: return FULL_NEG;
                2: return '0;
                default: return '1;
            endcase
        end
        if (r < 45)
            return sample_t'(int'($urandom_range(65535)) - 32768);
        return sample_t'($urandom);
    endfunction

    function automatic logic [COEF_W-1:0] coef_between(int lo, int hi);
        return COEF_W'(int'($urandom_range(hi - lo)) + lo);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_b(logic [COEF_W-1:0] b0,
                                                     logic [COEF_W-1:0] b1,
                                                     logic [COEF_W-1:0] b2);
        return {b2, b1, b0};
    endfunction

    // junk above the a register width must be dropped
    function automatic logic [CFG_DATA_W-1:0] pack_a(logic [COEF_W-1:0] a1,
                                                     logic [COEF_W-1:0] a2);
        return {COEF_W'($urandom), a2, a1};
    endfunction

    task automatic send_sample(sample_t value, int ch, bit restart);
        repeat (pick_gap()) @(negedge clk);
        samples_if.sample_in = value;
        samples_if.channel   = ch[CHAN_W-1:0];
        samples_if.restart   = restart;
        samples_if.valid     = 1'b1;
        @(posedge clk);
        while (!samples_if.ready) @(posedge clk);
        @(negedge clk);
        samples_if.valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_if.index = idx;
        cfg_if.data  = value;
        cfg_if.valid = 1'b1;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // hold off until every result is back and the sequencer has settled
    task automatic wait_drained();
        while (results_owed != 0) @(negedge clk);
        repeat (ITEM_LATENCY) @(negedge clk);
    endtask

    task automatic load_coefs(coef_mode_t mode);
        logic [CFG_IDX_W-1:0] b_regs [NUM_STAGES];
        logic [CFG_IDX_W-1:0] a_regs [NUM_STAGES];
        logic [COEF_W-1:0]    f [MAC_STEPS];
        b_regs = '{REG_LOW_B, REG_MID_B, REG_HIGH_B};
        a_regs = '{REG_LOW_A, REG_MID_A, REG_HIGH_A};
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            // f holds b0, b1, b2, a1, a2
            for (int k = 0; k < MAC_STEPS; k++)
            begin
                case (mode)
                    COEF_PASS:   f[k] = (k == 0) ? COEF_ONE : '0;
                    COEF_WILD:   f[k] = COEF_W'($urandom);
                    COEF_TOP:    f[k] = COEF_MAX_POS;
                    COEF_BOTTOM: f[k] = COEF_MAX_NEG;
                    default:
                    begin
                        // near unity gain, stable feedback
                        case (k)
                            0:       f[k] = coef_between(45000, 85000);
                            3:       f[k] = coef_between(-40000, 40000);
                            4:       f[k] = coef_between(-20000, 20000);
                            default: f[k] = coef_between(-40000, 40000);
                        endcase
                    end
                endcase
            end
            write_reg(b_regs[s], pack_b(f[0], f[1], f[2]));
            write_reg(a_regs[s], pack_a(f[3], f[4]));
        end
    endtask

    // result side: ready with random stalls
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                results_if.ready = 1'b0;
            else if (stall_left > 0)
            begin
                results_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                results_if.ready = 1'b1;
                if (idle_en && $urandom_range(99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog on cycles with no item moving on any channel
    always @(posedge clk)
    begin
        if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        coef_mode_t plan [8];
        samples_if.valid     = 1'b0;
        samples_if.sample_in = '0;
        samples_if.channel   = '0;
        samples_if.restart   = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset pass-through: extremes and alternating bit patterns
        send_sample('0, 0, 1'b1);
        send_sample(FULL_POS, 0, 1'b0);
        send_sample(FULL_NEG, 1, 1'b0);
        send_sample('1, 7, 1'b0);
        send_sample(sample_t'(1), 2, 1'b1);
        send_sample(sample_t'({(SW/2){2'b01}}), 3, 1'b0);
        send_sample(sample_t'({(SW/2){2'b10}}), 4, 1'b0);
        wait_drained();

        // writes past the map are dropped; then gain and feedback to reach both rails
        write_reg(REG_UNMAPPED_LO, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_UNMAPPED_HI, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_LOW_B, pack_b(COEF_TWO, COEF_HALF, '0));
        write_reg(REG_MID_A, pack_a(COEF_NEG_HALF, '0));
        send_sample(FULL_POS, 5, 1'b0);
        send_sample(FULL_POS, 5, 1'b0);
        send_sample(FULL_NEG, 5, 1'b0);
        send_sample(FULL_NEG, 5, 1'b0);
        // restart on a channel with history
        send_sample(FULL_POS, 5, 1'b1);
        send_sample('0, 5, 1'b0);
        send_sample(FULL_NEG, 6, 1'b1);
        send_sample(sample_t'(1), 6, 1'b0);
        send_sample(FULL_POS, 7, 1'b0);
        send_sample('1, 0, 1'b0);
        wait_drained();

        // random phases, each with its own coefficient set
        plan = '{COEF_GENTLE, COEF_GENTLE, COEF_WILD, COEF_TOP,
                 COEF_GENTLE, COEF_BOTTOM, COEF_GENTLE, COEF_PASS};
        foreach (plan[p])
        begin
            load_coefs(plan[p]);
            idle_en = (p != 1) && (p != 6);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off mid-phase until everything is back
                if (p == 4 && i == PHASE_ITEMS / 2)
                    wait_drained();
                send_sample(pick_sample(), $urandom_range(MAX_CH - 1),
                            $urandom_range(99) < 4);
            end
            wait_drained();
        end

        if (error_count == 0 && results_owed == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
